// ===== rtl/samf_pkg.sv =====
package samf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCOPE_W  = 30;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] CFG_CAPTURE_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CAPTURE_GAIN  = 3'd1;
    localparam logic [IDX_W-1:0] CFG_ENG0_VOLUME   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ENG1_VOLUME   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_THRU_ENABLE   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_THRU_VOLUME   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_OUTPUT_VOLUME = 3'd6;

    typedef enum logic [1:0] {
        MODE_STEREO     = 2'd0,
        MODE_LEFT_BOTH  = 2'd1,
        MODE_RIGHT_BOTH = 2'd2,
        MODE_RAW        = 2'd3
    } t_capture_mode;

    localparam logic [14:0] GAIN_RESET     = 15'd256;
    localparam logic [15:0] ENG_VOL_RESET  = 16'd4096;
    localparam logic [15:0] Q15_UNITY      = 16'd32768;
    localparam logic signed [24:0] SAT_POS = 25'sd32767;
    localparam logic signed [24:0] SAT_NEG = -25'sd32767;

endpackage

// ===== rtl/samf_in_if.sv =====
interface samf_in_if;
    import samf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] rx_left;
    logic signed [SAMPLE_W-1:0] rx_right;
    logic signed [SAMPLE_W-1:0] eng0_left;
    logic signed [SAMPLE_W-1:0] eng0_right;
    logic signed [SAMPLE_W-1:0] eng1_left;
    logic signed [SAMPLE_W-1:0] eng1_right;
    logic                       eng0_active;
    logic                       eng1_active;

    modport source (
        output valid, rx_left, rx_right, eng0_left, eng0_right, eng1_left, eng1_right,
               eng0_active, eng1_active,
        input  ready
    );

    modport sink (
        input  valid, rx_left, rx_right, eng0_left, eng0_right, eng1_left, eng1_right,
               eng0_active, eng1_active,
        output ready
    );

endinterface

// ===== rtl/samf_out_if.sv =====
interface samf_out_if;
    import samf_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] tx_left;
    logic signed [SAMPLE_W-1:0] tx_right;
    logic signed [SCOPE_W-1:0]  scope_value;

    modport source (
        output valid, tx_left, tx_right, scope_value,
        input  ready
    );

    modport sink (
        input  valid, tx_left, tx_right, scope_value,
        output ready
    );

endinterface

// ===== rtl/stereo_audio_mixer_frame_core.sv =====
// Stereo audio mixer, one stereo frame per transfer.
// i_frame carries the captured left/right pair, a left/right pair from each
// of two synthesis engines and an active flag per engine. o_frame returns
// the mixed, volume-scaled and saturated left/right pair plus a scope value
// (engine mix of both sides, arithmetic shift right three).
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the
// user must write it only while no frame is in flight, which the block
// does not enforce. Indexes past the output volume are ignored.
// Throughput is one frame per cycle while o_frame.ready stays high: five
// register stages (capture and engine multiplies, mode select and
// pass-through multiply, accumulate, output-volume multiply, saturate)
// each hold one frame, and o_frame.valid is the valid bit of the last.
// Reset empties the pipeline and loads the default registers: raw capture,
// unity gains, pass-through off.
// When the receiver stalls, each stage holds its frame and only stages with
// a free slot downstream advance; bubbles close up, so the block keeps
// taking frames until all five stages are full, then drops i_frame.ready.
module stereo_audio_mixer_frame_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [samf_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [samf_pkg::CFG_W-1:0]  i_cfg_data,
    samf_in_if.sink                     i_frame,
    samf_out_if.source                  o_frame
);
    import samf_pkg::*;

    t_capture_mode r_mode;
    logic [14:0]   r_gain;
    logic [15:0]   r_eng0_vol;
    logic [15:0]   r_eng1_vol;
    logic          r_thru_en;
    logic [15:0]   r_thru_vol;
    logic [15:0]   r_out_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RAW;
            r_gain     <= GAIN_RESET;
            r_eng0_vol <= ENG_VOL_RESET;
            r_eng1_vol <= ENG_VOL_RESET;
            r_thru_en  <= 1'b0;
            r_thru_vol <= Q15_UNITY;
            r_out_vol  <= Q15_UNITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAPTURE_MODE:  r_mode     <= t_capture_mode'(i_cfg_data[1:0]);
                CFG_CAPTURE_GAIN:  r_gain     <= i_cfg_data[14:0];
                CFG_ENG0_VOLUME:   r_eng0_vol <= i_cfg_data;
                CFG_ENG1_VOLUME:   r_eng1_vol <= i_cfg_data;
                CFG_THRU_ENABLE:   r_thru_en  <= i_cfg_data[0];
                CFG_THRU_VOLUME:   r_thru_vol <= i_cfg_data;
                CFG_OUTPUT_VOLUME: r_out_vol  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic s1_en, s2_en, s3_en, s4_en, s5_en;

    assign s5_en = !r_v5 || o_frame.ready;
    assign s4_en = !r_v4 || s5_en;
    assign s3_en = !r_v3 || s4_en;
    assign s2_en = !r_v2 || s3_en;
    assign s1_en = !r_v1 || s2_en;
    assign i_frame.ready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s1_en) r_v1 <= i_frame.valid;
            if (s2_en) r_v2 <= r_v1;
            if (s3_en) r_v3 <= r_v2;
            if (s4_en) r_v4 <= r_v3;
            if (s5_en) r_v5 <= r_v4;
        end
    end

    // stage 1: capture gain and engine volume products
    logic signed [31:0] n_cap_l, n_cap_r;
    logic signed [32:0] n_e0_l, n_e0_r, n_e1_l, n_e1_r;
    logic signed [31:0] r_cap_l, r_cap_r;
    logic signed [32:0] r_e0_l, r_e0_r, r_e1_l, r_e1_r;
    logic signed [15:0] r_raw_l, r_raw_r;

    always_comb begin
        n_cap_l = 32'(i_frame.rx_left)  * 32'($signed({1'b0, r_gain}));
        n_cap_r = 32'(i_frame.rx_right) * 32'($signed({1'b0, r_gain}));
        n_e0_l  = i_frame.eng0_active ?
                  33'(i_frame.eng0_left)  * 33'($signed({1'b0, r_eng0_vol})) : '0;
        n_e0_r  = i_frame.eng0_active ?
                  33'(i_frame.eng0_right) * 33'($signed({1'b0, r_eng0_vol})) : '0;
        n_e1_l  = i_frame.eng1_active ?
                  33'(i_frame.eng1_left)  * 33'($signed({1'b0, r_eng1_vol})) : '0;
        n_e1_r  = i_frame.eng1_active ?
                  33'(i_frame.eng1_right) * 33'($signed({1'b0, r_eng1_vol})) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_cap_l <= n_cap_l;
            r_cap_r <= n_cap_r;
            r_e0_l  <= n_e0_l;
            r_e0_r  <= n_e0_r;
            r_e1_l  <= n_e1_l;
            r_e1_r  <= n_e1_r;
            r_raw_l <= i_frame.rx_left;
            r_raw_r <= i_frame.rx_right;
        end
    end

    // stage 2: capture mode select, pass-through product, engine sums
    logic signed [15:0] c_l, c_r;
    logic signed [32:0] n_thru_l, n_thru_r;
    logic signed [21:0] n_acc_l, n_acc_r;
    logic signed [32:0] r_thru_l, r_thru_r;
    logic signed [21:0] r_acc_l, r_acc_r;

    always_comb begin
        unique case (r_mode)
            MODE_STEREO: begin
                c_l = r_cap_l[23:8];
                c_r = r_cap_r[23:8];
            end
            MODE_LEFT_BOTH: begin
                c_l = r_cap_l[23:8];
                c_r = r_cap_l[23:8];
            end
            MODE_RIGHT_BOTH: begin
                c_l = r_cap_r[23:8];
                c_r = r_cap_r[23:8];
            end
            default: begin
                c_l = r_raw_l;
                c_r = r_raw_r;
            end
        endcase
        n_thru_l = 33'(c_l) * 33'($signed({1'b0, r_thru_vol}));
        n_thru_r = 33'(c_r) * 33'($signed({1'b0, r_thru_vol}));
        n_acc_l  = 22'($signed(r_e0_l[32:12])) + 22'($signed(r_e1_l[32:12]));
        n_acc_r  = 22'($signed(r_e0_r[32:12])) + 22'($signed(r_e1_r[32:12]));
    end

    always_ff @(posedge i_clk) begin
        if (s2_en) begin
            r_thru_l <= n_thru_l;
            r_thru_r <= n_thru_r;
            r_acc_l  <= n_acc_l;
            r_acc_r  <= n_acc_r;
        end
    end

    // stage 3: add pass-through, form scope value
    logic signed [22:0] n_sum_l, n_sum_r, scope_sum;
    logic signed [17:0] thru_t_l, thru_t_r;
    logic signed [22:0] r_sum_l, r_sum_r;
    logic signed [SCOPE_W-1:0] n_scope, r_scope3, r_scope4, r_scope5;

    always_comb begin
        thru_t_l  = r_thru_en ? r_thru_l[32:15] : '0;
        thru_t_r  = r_thru_en ? r_thru_r[32:15] : '0;
        n_sum_l   = 23'(r_acc_l) + 23'(thru_t_l);
        n_sum_r   = 23'(r_acc_r) + 23'(thru_t_r);
        scope_sum = 23'(r_acc_l) + 23'(r_acc_r);
        n_scope   = SCOPE_W'($signed(scope_sum[22:3]));
    end

    always_ff @(posedge i_clk) begin
        if (s3_en) begin
            r_sum_l  <= n_sum_l;
            r_sum_r  <= n_sum_r;
            r_scope3 <= n_scope;
        end
    end

    // stage 4: output volume product
    logic signed [39:0] n_ov_l, n_ov_r, r_ov_l, r_ov_r;

    always_comb begin
        n_ov_l = 40'(r_sum_l) * 40'($signed({1'b0, r_out_vol}));
        n_ov_r = 40'(r_sum_r) * 40'($signed({1'b0, r_out_vol}));
    end

    always_ff @(posedge i_clk) begin
        if (s4_en) begin
            r_ov_l   <= n_ov_l;
            r_ov_r   <= n_ov_r;
            r_scope4 <= r_scope3;
        end
    end

    // stage 5: saturate
    logic signed [24:0] sc_l, sc_r;
    logic signed [15:0] n_tx_l, n_tx_r, r_tx_l, r_tx_r;

    always_comb begin
        sc_l = r_ov_l[39:15];
        sc_r = r_ov_r[39:15];
        priority if (sc_l > SAT_POS) n_tx_l = SAT_POS[15:0];
        else if (sc_l < SAT_NEG)     n_tx_l = SAT_NEG[15:0];
        else                         n_tx_l = sc_l[15:0];
        priority if (sc_r > SAT_POS) n_tx_r = SAT_POS[15:0];
        else if (sc_r < SAT_NEG)     n_tx_r = SAT_NEG[15:0];
        else                         n_tx_r = sc_r[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (s5_en) begin
            r_tx_l   <= n_tx_l;
            r_tx_r   <= n_tx_r;
            r_scope5 <= r_scope4;
        end
    end

    assign o_frame.valid       = r_v5;
    assign o_frame.tx_left     = r_tx_l;
    assign o_frame.tx_right    = r_tx_r;
    assign o_frame.scope_value = r_scope5;

endmodule

// ===== tb/sv/mixer_check.sv =====
`timescale 1ns / 1ps

module mixer_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [samf_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [samf_pkg::CFG_W-1:0] i_cfg_data,
    samf_in_if                         frame_in,
    samf_out_if                        frame_out,
    output int                         o_fail_count,
    output int                         o_pending
);
    import samf_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] tx_left;
        logic signed [SAMPLE_W-1:0] tx_right;
        logic signed [SCOPE_W-1:0]  scope_value;
    } t_mix_result;

    t_capture_mode cfg_mode;
    logic [14:0]   cfg_gain;
    logic [15:0]   cfg_eng0_vol;
    logic [15:0]   cfg_eng1_vol;
    logic          cfg_thru_en;
    logic [15:0]   cfg_thru_vol;
    logic [15:0]   cfg_out_vol;
    t_mix_result   pending_mixes[$];
    t_mix_result   want;
    int            failures = 0;

    function automatic logic signed [15:0] gained(input logic signed [15:0] x);
        longint p;
        p = (longint'(x) * longint'(cfg_gain)) >>> 8;
        return p[15:0];
    endfunction

    function automatic longint engine_part(input logic signed [15:0] s, input logic act,
                                           input logic [15:0] vol);
        if (!act || vol == 16'd0) begin
            return 0;
        end
        return (longint'(s) * longint'(vol)) >>> 12;
    endfunction

    function automatic logic signed [15:0] finish_side(input longint acc,
                                                       input logic signed [15:0] rx);
        longint sum;
        sum = acc;
        if (cfg_thru_en) begin
            sum += (longint'(rx) * longint'(cfg_thru_vol)) >>> 15;
        end
        sum = (sum * longint'(cfg_out_vol)) >>> 15;
        if (sum > longint'(SAT_POS)) begin
            sum = longint'(SAT_POS);
        end else if (sum < longint'(SAT_NEG)) begin
            sum = longint'(SAT_NEG);
        end
        return sum[15:0];
    endfunction

    function automatic t_mix_result mix_frame(
        input logic signed [15:0] rl, rr, e0l, e0r, e1l, e1r,
        input logic a0, a1
    );
        logic signed [15:0] cl;
        logic signed [15:0] cr;
        longint             accl;
        longint             accr;
        longint             scope_sum;
        t_mix_result        r;
        case (cfg_mode)
            MODE_STEREO: begin
                cl = gained(rl);
                cr = gained(rr);
            end
            MODE_LEFT_BOTH: begin
                cl = gained(rl);
                cr = cl;
            end
            MODE_RIGHT_BOTH: begin
                cr = gained(rr);
                cl = cr;
            end
            default: begin
                cl = rl;
                cr = rr;
            end
        endcase
        accl = engine_part(e0l, a0, cfg_eng0_vol) + engine_part(e1l, a1, cfg_eng1_vol);
        accr = engine_part(e0r, a0, cfg_eng0_vol) + engine_part(e1r, a1, cfg_eng1_vol);
        scope_sum     = (accl + accr) >>> 3;
        r.tx_left     = finish_side(accl, cl);
        r.tx_right    = finish_side(accr, cr);
        r.scope_value = scope_sum[SCOPE_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] act_v);
        if (act_v !== exp_v) begin
            failures++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mode     = MODE_RAW;
            cfg_gain     = GAIN_RESET;
            cfg_eng0_vol = ENG_VOL_RESET;
            cfg_eng1_vol = ENG_VOL_RESET;
            cfg_thru_en  = 1'b0;
            cfg_thru_vol = Q15_UNITY;
            cfg_out_vol  = Q15_UNITY;
            pending_mixes.delete();
        end else begin
            if (frame_out.valid && frame_out.ready) begin
                if (pending_mixes.size() == 0) begin
                    failures++;
                    $display("%0t: result with nothing expected, actual %0d %0d %0d",
                             $time, frame_out.tx_left, frame_out.tx_right,
                             frame_out.scope_value);
                end else begin
                    want = pending_mixes.pop_front();
                    check_field("tx_left", want.tx_left, frame_out.tx_left);
                    check_field("tx_right", want.tx_right, frame_out.tx_right);
                    check_field("scope_value", want.scope_value, frame_out.scope_value);
                end
            end
            if (frame_in.valid && frame_in.ready) begin
                pending_mixes.push_back(mix_frame(
                    frame_in.rx_left, frame_in.rx_right,
                    frame_in.eng0_left, frame_in.eng0_right,
                    frame_in.eng1_left, frame_in.eng1_right,
                    frame_in.eng0_active, frame_in.eng1_active));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CAPTURE_MODE:  cfg_mode     = t_capture_mode'(i_cfg_data[1:0]);
                    CFG_CAPTURE_GAIN:  cfg_gain     = i_cfg_data[14:0];
                    CFG_ENG0_VOLUME:   cfg_eng0_vol = i_cfg_data;
                    CFG_ENG1_VOLUME:   cfg_eng1_vol = i_cfg_data;
                    CFG_THRU_ENABLE:   cfg_thru_en  = i_cfg_data[0];
                    CFG_THRU_VOLUME:   cfg_thru_vol = i_cfg_data;
                    CFG_OUTPUT_VOLUME: cfg_out_vol  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= pending_mixes.size();
        o_fail_count <= failures;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import samf_pkg::*;

    localparam logic [IDX_W-1:0] CFG_UNUSED_IDX = CFG_OUTPUT_VOLUME + 3'd1;

    typedef struct {
        logic [15:0] rx_left;
        logic [15:0] rx_right;
        logic [15:0] eng0_left;
        logic [15:0] eng0_right;
        logic [15:0] eng1_left;
        logic [15:0] eng1_right;
        logic        eng0_active;
        logic        eng1_active;
    } t_stereo_frame;

    typedef struct {
        t_capture_mode mode;
        logic [14:0]   gain;
        logic [15:0]   eng0_vol;
        logic [15:0]   eng1_vol;
        logic          thru_en;
        logic [15:0]   thru_vol;
        logic [15:0]   out_vol;
    } t_mixer_setup;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_data;
    int               fail_count;
    int               pending;
    int               idle_pct = 20;

    samf_in_if  in_if ();
    samf_out_if out_if ();

    stereo_audio_mixer_frame_core u_top (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .i_frame (in_if),
        .o_frame (out_if)
    );

    mixer_check u_check (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_idx,
        .i_cfg_data,
        .frame_in     (in_if),
        .frame_out    (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_stereo_frame make_frame(
        input logic [15:0] rl, rr, e0l, e0r, e1l, e1r,
        input logic a0, a1
    );
        t_stereo_frame f;
        f.rx_left     = rl;
        f.rx_right    = rr;
        f.eng0_left   = e0l;
        f.eng0_right  = e0r;
        f.eng1_left   = e1l;
        f.eng1_right  = e1r;
        f.eng0_active = a0;
        f.eng1_active = a1;
        return f;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_stereo_frame random_frame();
        return make_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                          rand_sample(), rand_sample(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic t_mixer_setup make_setup(
        input t_capture_mode mode,
        input logic [14:0]   gain,
        input logic [15:0]   v0, v1,
        input logic          te,
        input logic [15:0]   tv, ov
    );
        t_mixer_setup s;
        s.mode     = mode;
        s.gain     = gain;
        s.eng0_vol = v0;
        s.eng1_vol = v1;
        s.thru_en  = te;
        s.thru_vol = tv;
        s.out_vol  = ov;
        return s;
    endfunction

    function automatic logic [15:0] pick_level(input logic [15:0] unity, input logic [15:0] top);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return top;
            2:       return unity;
            3:       return 16'($urandom_range(0, unity));
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic t_mixer_setup random_setup();
        return make_setup(t_capture_mode'($urandom_range(0, 3)),
                          15'(pick_level(16'(GAIN_RESET), 16'h7FFF)),
                          pick_level(ENG_VOL_RESET, 16'hFFFF),
                          pick_level(ENG_VOL_RESET, 16'hFFFF),
                          1'($urandom_range(0, 1)),
                          pick_level(Q15_UNITY, 16'hFFFF),
                          pick_level(Q15_UNITY, 16'hFFFF));
    endfunction

    // fill the bits above the register width with noise
    function automatic logic [CFG_W-1:0] cfg_word(input logic [CFG_W-1:0] v, input int w);
        logic [CFG_W-1:0] upper;
        upper = {CFG_W{1'b1}} << w;
        return (v & ~upper) | (16'($urandom) & upper);
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input t_mixer_setup s);
        write_reg(CFG_CAPTURE_MODE, cfg_word({14'd0, s.mode}, 2));
        write_reg(CFG_CAPTURE_GAIN, cfg_word({1'b0, s.gain}, 15));
        write_reg(CFG_ENG0_VOLUME, s.eng0_vol);
        write_reg(CFG_ENG1_VOLUME, s.eng1_vol);
        write_reg(CFG_THRU_ENABLE, cfg_word({15'd0, s.thru_en}, 1));
        write_reg(CFG_THRU_VOLUME, s.thru_vol);
        write_reg(CFG_OUTPUT_VOLUME, s.out_vol);
        write_reg(CFG_UNUSED_IDX, 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input t_stereo_frame f);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.rx_left     <= f.rx_left;
        in_if.rx_right    <= f.rx_right;
        in_if.eng0_left   <= f.eng0_left;
        in_if.eng0_right  <= f.eng0_right;
        in_if.eng1_left   <= f.eng1_left;
        in_if.eng1_right  <= f.eng1_right;
        in_if.eng0_active <= f.eng0_active;
        in_if.eng1_active <= f.eng1_active;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
    endtask

    task automatic wait_drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        in_if.valid       <= 1'b0;
        in_if.rx_left     <= '0;
        in_if.rx_right    <= '0;
        in_if.eng0_left   <= '0;
        in_if.eng0_right  <= '0;
        in_if.eng1_left   <= '0;
        in_if.eng1_right  <= '0;
        in_if.eng0_active <= 1'b0;
        in_if.eng1_active <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_frame(make_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h1234, 16'hEDCB, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                              1'b1, 1'b0));
        send_frame(make_frame(16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFF,
                              1'b0, 1'b1));
        send_frame(make_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                              1'b0, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF,
                              1'b1, 1'b1));

        wait_drain();
        apply_setup(make_setup(MODE_STEREO, 15'h7FFF, 16'hFFFF, 16'h0000, 1'b1,
                               16'hFFFF, 16'hFFFF));
        send_frame(make_frame(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h1234, 16'h4321,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000,
                              1'b0, 1'b1));
        send_frame(make_frame(16'h0100, 16'hFF00, 16'h0010, 16'hFFF0, 16'h0000, 16'h0000,
                              1'b1, 1'b0));
        send_frame(make_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              1'b1, 1'b1));

        wait_drain();
        apply_setup(make_setup(MODE_LEFT_BOTH, GAIN_RESET, ENG_VOL_RESET, ENG_VOL_RESET, 1'b1,
                               Q15_UNITY, Q15_UNITY));
        send_frame(make_frame(16'h1234, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b0, 1'b0));
        send_frame(make_frame(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
                              1'b1, 1'b0));
        send_frame(make_frame(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h8000, 16'h8000,
                              1'b0, 1'b1));
        send_frame(make_frame(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                              1'b1, 1'b1));

        wait_drain();
        apply_setup(make_setup(MODE_RIGHT_BOTH, 15'h4000, 16'h0000, 16'hFFFF, 1'b1,
                               16'h8000, 16'h4000));
        send_frame(make_frame(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h0003, 16'hFFFD, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF,
                              1'b1, 1'b1));
        send_frame(make_frame(16'h7FFF, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b0, 1'b0));
        send_frame(make_frame(16'h1111, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                              1'b0, 1'b1));

        for (int p = 0; p < 14; p++) begin
            wait_drain();
            apply_setup(random_setup());
            idle_pct = (p == 13) ? 0 : 20 * $urandom_range(0, 2);
            for (int n = 0; n < 100; n++) begin
                if (p == 6 && n == 50) begin
                    wait_drain();
                end
                send_frame(random_frame());
            end
        end

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== stereo_audio_mixer_frame_core.f =====
rtl/samf_pkg.sv
rtl/samf_in_if.sv
rtl/samf_out_if.sv
rtl/stereo_audio_mixer_frame_core.sv
tb/sv/mixer_check.sv
tb/sv/tb.sv
